// ----- rtl/core/optical_preamble_frame_sync_top_defines.svh -----
// ----------------------------------------------------------------------------
// Optical preamble frame sync assertion macros
// Shared concurrent check shorthands, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef OPTICAL_PREAMBLE_FRAME_SYNC_TOP_DEFINES_SVH
`define OPTICAL_PREAMBLE_FRAME_SYNC_TOP_DEFINES_SVH

// same-cycle implication
`define OPFS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define OPFS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/opfs_pkg.sv -----
// ----------------------------------------------------------------------------
// opfs_pkg
// Widths, register map, reset values and shared types of the frame sync.
// ----------------------------------------------------------------------------
package opfs_pkg;

   localparam int SAMPLE_W  = 10;
   localparam int THRESH_W  = 10;
   localparam int PATTERN_W = 8;
   localparam int PLEN_W    = 4;
   localparam int FLEN_W    = 12;
   localparam int DATA_W    = 32;
   localparam int ADDR_W    = 4;

   localparam int PREAMBLE_BITS         = 8;
   localparam int POSITION_BITS_DEFAULT = 12;

   localparam logic [THRESH_W-1:0]  THRESH_RESET  = THRESH_W'(400);
   localparam logic [PATTERN_W-1:0] PATTERN_RESET = PATTERN_W'(85);
   localparam logic [PLEN_W-1:0]    PLEN_RESET    = PLEN_W'(8);
   localparam logic [FLEN_W-1:0]    FLEN_RESET    = FLEN_W'(168);

   typedef enum logic [1:0] {
      REG_SLICE_THRESHOLD  = 2'd0,
      REG_PREAMBLE_PATTERN = 2'd1,
      REG_PREAMBLE_LENGTH  = 2'd2,
      REG_FRAME_LENGTH     = 2'd3
   } opfs_reg_type;

   typedef struct packed {
      logic [THRESH_W-1:0]  slice_threshold;
      logic [PATTERN_W-1:0] preamble_pattern;
      logic [PLEN_W-1:0]    preamble_length;
      logic [FLEN_W-1:0]    frame_length;
   } opfs_cfg_type;

   typedef struct packed {
      logic sliced_bit;
      logic payload_valid;
      logic payload_last;
   } opfs_result_type;

   typedef struct packed {
      logic hunting_preamble;
      logic receiving_payload;
   } opfs_state_type;

   // expected preamble bit at a position; position 0 is the start bit
   function automatic logic expected_bit(logic [PLEN_W-1:0] pos,
                                         logic [PATTERN_W-1:0] pattern);
      logic result;
      if (pos == '0) begin
         result = 1'b1;
      end else if ((int'(pos) < PREAMBLE_BITS) && (int'(pos) < PATTERN_W)) begin
         result = pattern[pos[$clog2(PATTERN_W)-1:0]];
      end else begin
         result = 1'b0;
      end
      return result;
   endfunction

endpackage

// ----- rtl/core/opfs_req_if.sv -----
// ----------------------------------------------------------------------------
// opfs_req_if
// Sample request channel: valid/ready handshake with one sensor reading.
// ----------------------------------------------------------------------------
interface opfs_req_if;
   logic                          valid;
   logic                          ready;
   logic [opfs_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// ----- rtl/core/opfs_rsp_if.sv -----
// ----------------------------------------------------------------------------
// opfs_rsp_if
// Result channel: sliced bit plus payload valid and last markers.
// ----------------------------------------------------------------------------
interface opfs_rsp_if;
   logic valid;
   logic ready;
   logic sliced_bit;
   logic payload_valid;
   logic payload_last;

   modport source (output valid, output sliced_bit, output payload_valid,
                   output payload_last, input ready);
   modport sink   (input valid, input sliced_bit, input payload_valid,
                   input payload_last, output ready);
endinterface

// ----- rtl/core/opfs_csr.sv -----
// ----------------------------------------------------------------------------
// opfs_csr
// APB register bank: threshold, preamble pattern/length, frame length.
// ----------------------------------------------------------------------------
module opfs_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [opfs_pkg::ADDR_W-1:0]  paddr,
   input  logic [opfs_pkg::DATA_W-1:0]  pwdata,
   output logic [opfs_pkg::DATA_W-1:0]  prdata,
   output logic                         pready,
   output opfs_pkg::opfs_cfg_type       cfg
);
   import opfs_pkg::*;

   opfs_cfg_type cfg_ff, cfg_in;
   opfs_reg_type reg_sel;
   logic         wr_en;

   assign reg_sel = opfs_reg_type'(paddr[3:2]);
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_SLICE_THRESHOLD:  cfg_in.slice_threshold  = pwdata[THRESH_W-1:0];
            REG_PREAMBLE_PATTERN: cfg_in.preamble_pattern = pwdata[PATTERN_W-1:0];
            REG_PREAMBLE_LENGTH:  cfg_in.preamble_length  = pwdata[PLEN_W-1:0];
            REG_FRAME_LENGTH:     cfg_in.frame_length     = pwdata[FLEN_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_SLICE_THRESHOLD:  prdata = DATA_W'(cfg_ff.slice_threshold);
         REG_PREAMBLE_PATTERN: prdata = DATA_W'(cfg_ff.preamble_pattern);
         REG_PREAMBLE_LENGTH:  prdata = DATA_W'(cfg_ff.preamble_length);
         REG_FRAME_LENGTH:     prdata = DATA_W'(cfg_ff.frame_length);
         default:              prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slice_threshold  <= THRESH_RESET;
         cfg_ff.preamble_pattern <= PATTERN_RESET;
         cfg_ff.preamble_length  <= PLEN_RESET;
         cfg_ff.frame_length     <= FLEN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/core/opfs_framer.sv -----
// ----------------------------------------------------------------------------
// opfs_framer
// Slicer and preamble/payload state machine, one sample per cycle while take is high.
// ----------------------------------------------------------------------------
module opfs_framer #(
   parameter int POSITION_BITS = opfs_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          take,
   input  logic [opfs_pkg::SAMPLE_W-1:0] sample,
   input  opfs_pkg::opfs_cfg_type        cfg,
   output opfs_pkg::opfs_result_type     result,
   output opfs_pkg::opfs_state_type      state
);
   import opfs_pkg::*;

   localparam int CMP_W = ((POSITION_BITS > FLEN_W) ? POSITION_BITS : FLEN_W) + 1;

   logic                     hunt_ff, hunt_in;
   logic                     recv_ff, recv_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [CMP_W-1:0]         pos_ext, next_ext, plen_ext, flen_ext;
   logic                     bit_s, valid_s, last_s;

   assign bit_s    = (sample > cfg.slice_threshold);
   assign pos_ext  = CMP_W'(pos_ff);
   assign next_ext = pos_ext + CMP_W'(1);
   assign plen_ext = CMP_W'(cfg.preamble_length);
   assign flen_ext = CMP_W'(cfg.frame_length);

   always_comb begin
      hunt_in = hunt_ff;
      recv_in = recv_ff;
      pos_in  = pos_ff;
      valid_s = 1'b0;
      last_s  = 1'b0;
      if (!hunt_ff && !recv_ff && bit_s) begin
         hunt_in = 1'b1;
         pos_in  = POSITION_BITS'(1);
      end else if (hunt_ff && (pos_ext < plen_ext)) begin
         pos_in = next_ext[POSITION_BITS-1:0];
         if (bit_s != expected_bit(pos_ff[PLEN_W-1:0], cfg.preamble_pattern)) begin
            hunt_in = 1'b0;
            recv_in = 1'b0;
            pos_in  = '0;
         end
      end else if (hunt_ff && (pos_ext == plen_ext)) begin
         hunt_in = 1'b0;
         recv_in = 1'b1;
         valid_s = 1'b1;
         last_s  = (next_ext >= flen_ext);
         pos_in  = next_ext[POSITION_BITS-1:0];
      end else if (recv_ff && (pos_ext < flen_ext)) begin
         valid_s = 1'b1;
         last_s  = (next_ext >= flen_ext);
         pos_in  = next_ext[POSITION_BITS-1:0];
      end else begin
         hunt_in = 1'b0;
         recv_in = 1'b0;
         pos_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hunt_ff <= 1'b0;
         recv_ff <= 1'b0;
         pos_ff  <= '0;
      end else if (take) begin
         hunt_ff <= hunt_in;
         recv_ff <= recv_in;
         pos_ff  <= pos_in;
      end
   end

   assign result.sliced_bit      = bit_s;
   assign result.payload_valid   = valid_s;
   assign result.payload_last    = last_s;
   assign state.hunting_preamble  = hunt_ff;
   assign state.receiving_payload = recv_ff;

endmodule

// ----- rtl/core/opfs_out_queue.sv -----
// ----------------------------------------------------------------------------
// opfs_out_queue
// Two-entry result queue; decouples request ready from result ready.
// ----------------------------------------------------------------------------
module opfs_out_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  opfs_pkg::opfs_result_type push_data,
   input  logic                      pop,
   output logic                      not_full,
   output logic                      not_empty,
   output opfs_pkg::opfs_result_type head
);
   import opfs_pkg::*;

   opfs_result_type entry_ff [2];
   logic            wr_ptr_ff, wr_ptr_in;
   logic            rd_ptr_ff, rd_ptr_in;
   logic [1:0]      count_ff, count_in;

   assign not_full  = (count_ff != 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/core/optical_preamble_frame_sync_top.sv -----
// ----------------------------------------------------------------------------
// optical_preamble_frame_sync_top
// Slices light-sensor samples, finds the preamble, marks payload bits.
// ----------------------------------------------------------------------------
// Takes one sample request per clock while req ready is high and returns
// exactly one result per request, in the cycle after it is accepted at the
// earliest. The slicer and the preamble/payload next-state logic are combinational,
// which sets the rate at one request per clock; a two-entry result queue keeps
// requests flowing while a result waits, and req ready drops only when both
// entries are held. Registers are to be written over APB only while the block is idle (not enforced).
`include "optical_preamble_frame_sync_top_defines.svh"

module optical_preamble_frame_sync_top #(
   parameter int POSITION_BITS = opfs_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   opfs_req_if.sink                    req_chan,
   opfs_rsp_if.source                  rsp_chan,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [opfs_pkg::ADDR_W-1:0] paddr,
   input  logic [opfs_pkg::DATA_W-1:0] pwdata,
   output logic [opfs_pkg::DATA_W-1:0] prdata,
   output logic                        pready
);
   import opfs_pkg::*;

   opfs_cfg_type    cfg;
   opfs_result_type result;
   opfs_result_type head;
   opfs_state_type  state;
   logic            take;
   logic            pop;
   logic            not_full;
   logic            not_empty;

   assign take           = req_chan.valid & not_full;
   assign pop            = rsp_chan.ready & not_empty;
   assign req_chan.ready = not_full;

   opfs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   opfs_framer #(
      .POSITION_BITS (POSITION_BITS)
   ) u_framer (
      .clock  (clock),
      .reset  (reset),
      .take   (take),
      .sample (req_chan.sample),
      .cfg    (cfg),
      .result (result),
      .state  (state)
   );

   opfs_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (take),
      .push_data (result),
      .pop       (pop),
      .not_full  (not_full),
      .not_empty (not_empty),
      .head      (head)
   );

   assign rsp_chan.valid         = not_empty;
   assign rsp_chan.sliced_bit    = head.sliced_bit;
   assign rsp_chan.payload_valid = head.payload_valid;
   assign rsp_chan.payload_last  = head.payload_last;

   `OPFS_ASSERT_NOW(a_last_needs_valid, rsp_chan.valid && rsp_chan.payload_last, rsp_chan.payload_valid, "payload_last without payload_valid")
   `OPFS_ASSERT_NOW(a_state_exclusive, 1'b1, !(state.hunting_preamble && state.receiving_payload), "hunting and receiving at once")
   `OPFS_ASSERT_NOW(a_full_has_result, !not_full, not_empty, "queue full but no result shown")
   `OPFS_ASSERT_NEXT(a_accept_gives_result, take, rsp_chan.valid, "accepted request left no result")

endmodule
